>>> rtl/core/aat_pkg.sv
package aat_pkg;

   localparam int NUM_AXES = 3;
   localparam int COORD_W  = 24;
   localparam int COEF_W   = 18;
   localparam int ROW_W    = NUM_AXES * COEF_W;
   localparam int PROD_W   = COORD_W + COEF_W;
   localparam int FRAC_SHIFT = 16;
   localparam int TERM_W   = PROD_W - FRAC_SHIFT;
   localparam int SUM_W    = TERM_W + 2;
   localparam int BOX_W    = 2 * NUM_AXES * COORD_W;

   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;

   // register indexes (byte address = 8 * index)
   localparam logic [2:0] REG_MATRIX_ROW0 = 3'd0;
   localparam logic [2:0] REG_MATRIX_ROW1 = 3'd1;
   localparam logic [2:0] REG_MATRIX_ROW2 = 3'd2;
   localparam logic [2:0] REG_SHIFT_X     = 3'd3;
   localparam logic [2:0] REG_SHIFT_Y     = 3'd4;
   localparam logic [2:0] REG_SHIFT_Z     = 3'd5;

   // identity matrix: 1.0 in Q2.16 on the diagonal
   localparam logic [ROW_W-1:0] ROW0_RESET = ROW_W'(64'd65536);
   localparam logic [ROW_W-1:0] ROW1_RESET = ROW_W'(64'd65536 << COEF_W);
   localparam logic [ROW_W-1:0] ROW2_RESET = ROW_W'(64'd65536 << (2 * COEF_W));

   localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(32'sd8388607);
   localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(32'sd8388608);

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [NUM_AXES-1:0][COORD_W-1:0] coord_vec_type;
   typedef logic [ROW_W-1:0] row_type;

   // load enables of the pipeline stages
   typedef struct packed {
      logic en_mul;
      logic en_sel;
      logic en_sum;
      logic en_out;
   } stage_ctl_type;

endpackage

>>> rtl/core/aabb_affine_transform.sv
// Transforms an axis-aligned box by a 3x3 matrix plus translation and returns
// the tight axis-aligned box around the image (interval per matrix term).
//
// req_ channel: one box per item, min corner then max corner, Q16.8.
// rsp_ channel: one box per item, same packing, each coordinate saturated.
// csr_ port: matrix rows (three Q2.16 coefficients each) at 0x00/0x08/0x10,
// translation x/y/z at 0x18/0x20/0x28. Write only while no item is in flight.
//
// Pipeline: multiply, floor+order, sum, clamp, with 18 multipliers (one per
// term and corner) in parallel. An accepted box passes through the product,
// term, sum and output registers; one item per cycle while rsp_ is ready.
// Each stage loads when it is empty or the stage after it moves, so bubbles
// collapse and req_tready only drops when all four stages hold items that
// rsp_ has not taken. A stall holds rsp_tdata steady and loses nothing.
// Reset empties the pipeline and restores the identity matrix and zero
// translation.
module aabb_affine_transform (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // in_min_x, in_min_y, in_min_z, in_max_x, in_max_y, in_max_z (24 b each)
   input  logic [aat_pkg::BOX_W-1:0]         req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z
   output logic [aat_pkg::BOX_W-1:0]         rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [aat_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [aat_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [aat_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   aat_pkg::row_type      matrix_row_ff [aat_pkg::NUM_AXES];
   aat_pkg::coord_type    shift_ff      [aat_pkg::NUM_AXES];
   logic [2:0]            csr_index;
   logic                  csr_write;

   logic [3:0]            valid_ff, valid_in;
   logic [3:0]            stage_ready;
   aat_pkg::stage_ctl_type ctl;

   aat_pkg::coord_vec_type box_lo, box_hi;
   aat_pkg::coord_type    res_min [aat_pkg::NUM_AXES];
   aat_pkg::coord_type    res_max [aat_pkg::NUM_AXES];

   // configuration
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[5:3];
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_row_ff[0] <= aat_pkg::ROW0_RESET;
         matrix_row_ff[1] <= aat_pkg::ROW1_RESET;
         matrix_row_ff[2] <= aat_pkg::ROW2_RESET;
         shift_ff[0]      <= '0;
         shift_ff[1]      <= '0;
         shift_ff[2]      <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            aat_pkg::REG_MATRIX_ROW0: matrix_row_ff[0] <= csr_pwdata[aat_pkg::ROW_W-1:0];
            aat_pkg::REG_MATRIX_ROW1: matrix_row_ff[1] <= csr_pwdata[aat_pkg::ROW_W-1:0];
            aat_pkg::REG_MATRIX_ROW2: matrix_row_ff[2] <= csr_pwdata[aat_pkg::ROW_W-1:0];
            aat_pkg::REG_SHIFT_X:     shift_ff[0] <= csr_pwdata[aat_pkg::COORD_W-1:0];
            aat_pkg::REG_SHIFT_Y:     shift_ff[1] <= csr_pwdata[aat_pkg::COORD_W-1:0];
            aat_pkg::REG_SHIFT_Z:     shift_ff[2] <= csr_pwdata[aat_pkg::COORD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         aat_pkg::REG_MATRIX_ROW0: csr_prdata = aat_pkg::CSR_DATA_W'(matrix_row_ff[0]);
         aat_pkg::REG_MATRIX_ROW1: csr_prdata = aat_pkg::CSR_DATA_W'(matrix_row_ff[1]);
         aat_pkg::REG_MATRIX_ROW2: csr_prdata = aat_pkg::CSR_DATA_W'(matrix_row_ff[2]);
         aat_pkg::REG_SHIFT_X:
            csr_prdata = {{(aat_pkg::CSR_DATA_W-aat_pkg::COORD_W){1'b0}}, shift_ff[0]};
         aat_pkg::REG_SHIFT_Y:
            csr_prdata = {{(aat_pkg::CSR_DATA_W-aat_pkg::COORD_W){1'b0}}, shift_ff[1]};
         aat_pkg::REG_SHIFT_Z:
            csr_prdata = {{(aat_pkg::CSR_DATA_W-aat_pkg::COORD_W){1'b0}}, shift_ff[2]};
         default: csr_prdata = '0;
      endcase
   end

   // pipeline control: stage k loads when empty or when stage k+1 loads
   assign stage_ready[3] = ~valid_ff[3] | rsp_tready;
   assign stage_ready[2] = ~valid_ff[2] | stage_ready[3];
   assign stage_ready[1] = ~valid_ff[1] | stage_ready[2];
   assign stage_ready[0] = ~valid_ff[0] | stage_ready[1];

   assign ctl.en_mul = stage_ready[0];
   assign ctl.en_sel = stage_ready[1];
   assign ctl.en_sum = stage_ready[2];
   assign ctl.en_out = stage_ready[3];

   always_comb begin
      valid_in = valid_ff;
      if (stage_ready[0]) valid_in[0] = req_tvalid;
      if (stage_ready[1]) valid_in[1] = valid_ff[0];
      if (stage_ready[2]) valid_in[2] = valid_ff[1];
      if (stage_ready[3]) valid_in[3] = valid_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = stage_ready[0];
   assign rsp_tvalid = valid_ff[3];

   // datapath, one unit per output axis
   assign box_lo = req_tdata[aat_pkg::BOX_W/2-1:0];
   assign box_hi = req_tdata[aat_pkg::BOX_W-1:aat_pkg::BOX_W/2];

   for (genvar i = 0; i < aat_pkg::NUM_AXES; i++) begin : g_axis
      aat_axis u_axis (
         .clock   (clock),
         .ctl     (ctl),
         .row     (matrix_row_ff[i]),
         .shift   (shift_ff[i]),
         .box_lo  (box_lo),
         .box_hi  (box_hi),
         .out_min (res_min[i]),
         .out_max (res_max[i])
      );
      assign rsp_tdata[i*aat_pkg::COORD_W +: aat_pkg::COORD_W] = res_min[i];
      assign rsp_tdata[(i+aat_pkg::NUM_AXES)*aat_pkg::COORD_W +: aat_pkg::COORD_W] = res_max[i];
   end

endmodule

>>> rtl/core/aat_axis.sv
module aat_axis (
   input  logic                  clock,
   input  aat_pkg::stage_ctl_type ctl,
   input  aat_pkg::row_type      row,
   input  aat_pkg::coord_type    shift,
   input  aat_pkg::coord_vec_type box_lo,
   input  aat_pkg::coord_vec_type box_hi,
   output aat_pkg::coord_type    out_min,
   output aat_pkg::coord_type    out_max
);

   logic signed [aat_pkg::PROD_W-1:0] prod_lo_in [aat_pkg::NUM_AXES];
   logic signed [aat_pkg::PROD_W-1:0] prod_hi_in [aat_pkg::NUM_AXES];
   logic signed [aat_pkg::PROD_W-1:0] prod_lo_ff [aat_pkg::NUM_AXES];
   logic signed [aat_pkg::PROD_W-1:0] prod_hi_ff [aat_pkg::NUM_AXES];
   logic signed [aat_pkg::TERM_W-1:0] term_lo_in [aat_pkg::NUM_AXES];
   logic signed [aat_pkg::TERM_W-1:0] term_hi_in [aat_pkg::NUM_AXES];
   logic signed [aat_pkg::TERM_W-1:0] term_lo_ff [aat_pkg::NUM_AXES];
   logic signed [aat_pkg::TERM_W-1:0] term_hi_ff [aat_pkg::NUM_AXES];
   logic signed [aat_pkg::SUM_W-1:0]  sum_lo_in, sum_hi_in, sum_lo_ff, sum_hi_ff;
   logic signed [aat_pkg::SUM_W-1:0]  shift_ext;
   aat_pkg::coord_type                out_min_in, out_max_in, out_min_ff, out_max_ff;

   // stage 1: one multiplier per term and corner
   always_comb begin
      for (int j = 0; j < aat_pkg::NUM_AXES; j++) begin
         prod_lo_in[j] = $signed(row[j*aat_pkg::COEF_W +: aat_pkg::COEF_W])
                       * $signed(box_lo[j]);
         prod_hi_in[j] = $signed(row[j*aat_pkg::COEF_W +: aat_pkg::COEF_W])
                       * $signed(box_hi[j]);
      end
   end

   // stage 2: floor shift, then order the two products
   always_comb begin
      for (int j = 0; j < aat_pkg::NUM_AXES; j++) begin
         if ($signed(prod_lo_ff[j][aat_pkg::PROD_W-1:aat_pkg::FRAC_SHIFT]) >
             $signed(prod_hi_ff[j][aat_pkg::PROD_W-1:aat_pkg::FRAC_SHIFT])) begin
            term_lo_in[j] = prod_hi_ff[j][aat_pkg::PROD_W-1:aat_pkg::FRAC_SHIFT];
            term_hi_in[j] = prod_lo_ff[j][aat_pkg::PROD_W-1:aat_pkg::FRAC_SHIFT];
         end else begin
            term_lo_in[j] = prod_lo_ff[j][aat_pkg::PROD_W-1:aat_pkg::FRAC_SHIFT];
            term_hi_in[j] = prod_hi_ff[j][aat_pkg::PROD_W-1:aat_pkg::FRAC_SHIFT];
         end
      end
   end

   // stage 3: full-width sums, no saturation yet
   assign shift_ext = {{(aat_pkg::SUM_W-aat_pkg::COORD_W){shift[aat_pkg::COORD_W-1]}}, shift};

   always_comb begin
      sum_lo_in = shift_ext;
      sum_hi_in = shift_ext;
      for (int j = 0; j < aat_pkg::NUM_AXES; j++) begin
         sum_lo_in = sum_lo_in + aat_pkg::SUM_W'(term_lo_ff[j]);
         sum_hi_in = sum_hi_in + aat_pkg::SUM_W'(term_hi_ff[j]);
      end
   end

   // stage 4: clamp into the output register
   always_comb begin
      if (sum_lo_ff > aat_pkg::SAT_MAX) begin
         out_min_in = aat_pkg::SAT_MAX[aat_pkg::COORD_W-1:0];
      end else if (sum_lo_ff < aat_pkg::SAT_MIN) begin
         out_min_in = aat_pkg::SAT_MIN[aat_pkg::COORD_W-1:0];
      end else begin
         out_min_in = sum_lo_ff[aat_pkg::COORD_W-1:0];
      end
      if (sum_hi_ff > aat_pkg::SAT_MAX) begin
         out_max_in = aat_pkg::SAT_MAX[aat_pkg::COORD_W-1:0];
      end else if (sum_hi_ff < aat_pkg::SAT_MIN) begin
         out_max_in = aat_pkg::SAT_MIN[aat_pkg::COORD_W-1:0];
      end else begin
         out_max_in = sum_hi_ff[aat_pkg::COORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en_mul) begin
         prod_lo_ff <= prod_lo_in;
         prod_hi_ff <= prod_hi_in;
      end
      if (ctl.en_sel) begin
         term_lo_ff <= term_lo_in;
         term_hi_ff <= term_hi_in;
      end
      if (ctl.en_sum) begin
         sum_lo_ff <= sum_lo_in;
         sum_hi_ff <= sum_hi_in;
      end
      if (ctl.en_out) begin
         out_min_ff <= out_min_in;
         out_max_ff <= out_max_in;
      end
   end

   assign out_min = out_min_ff;
   assign out_max = out_max_ff;

endmodule

>>> rtl/core/aat_checker.sv
module aat_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [aat_pkg::BOX_W-1:0]      rsp_tdata,
   input logic                           csr_pready
);

   localparam int W = aat_pkg::COORD_W;

   // a stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp item changed while stalled");

   // an empty output stage means the whole pipeline can take an item
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req_tready low with no result waiting");

   // ordered terms and a monotonic clamp keep every result box well formed
   a_box_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         ($signed(rsp_tdata[0*W +: W]) <= $signed(rsp_tdata[3*W +: W])) &&
         ($signed(rsp_tdata[1*W +: W]) <= $signed(rsp_tdata[4*W +: W])) &&
         ($signed(rsp_tdata[2*W +: W]) <= $signed(rsp_tdata[5*W +: W])))
      else $error("result min exceeds max");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && csr_pready)
      else $error("result valid right after reset");

endmodule

bind aabb_affine_transform aat_checker u_aat_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_pready (csr_pready)
);
